[hw/rtl/piezo_knock_detector_defines.svh]
// Assertion macros for the knock detector checker (pkd_checker).
// Assumes clk and rst_n are visible in the including scope.
`ifndef PIEZO_KNOCK_DETECTOR_DEFINES_SVH
`define PIEZO_KNOCK_DETECTOR_DEFINES_SVH

// Clocked check, muted while reset is asserted.
`define PKD_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define PKD_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/pkd_pkg.sv]
// Shared constants, types and the running-average update for the knock detector.
// No dependencies.
`default_nettype none

package pkd_pkg;

    localparam int SAMPLE_BITS   = 10;
    localparam int FRAC_SHIFT    = 4;
    localparam int AVG_W         = 16;
    localparam int CTR_W         = AVG_W - FRAC_SHIFT;
    localparam int RPT_W         = 8;
    localparam int BAND_FLOOR_W  = 10;
    localparam int HOLD_W        = 16;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_IDX_W     = 1;
    localparam int REPORT_CENTER = 127;

    localparam logic [AVG_W-1:0] ROUND_OFS  = AVG_W'(1 << (FRAC_SHIFT - 1));
    localparam logic [RPT_W-1:0] REPORT_OFS =
        RPT_W'((1 << (SAMPLE_BITS - 1)) - REPORT_CENTER);

    localparam logic [AVG_W-1:0]        MID_AVG_RST    = AVG_W'(510);
    localparam logic [AVG_W-1:0]        HIGH_AVG_RST   = AVG_W'(520);
    localparam logic [AVG_W-1:0]        LOW_AVG_RST    = AVG_W'(500);
    localparam logic [BAND_FLOOR_W-1:0] BAND_FLOOR_RST = BAND_FLOOR_W'(16);
    localparam logic [HOLD_W-1:0]       HOLD_RST       = HOLD_W'(200);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BAND_FLOOR = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HOLD_COUNT = CFG_IDX_W'(1);

    typedef struct packed {
        logic [AVG_W-1:0]  mid_avg;
        logic [AVG_W-1:0]  high_avg;
        logic [AVG_W-1:0]  low_avg;
        logic [HOLD_W-1:0] hold_left;
        logic              switch_level;
    } pkd_state_t;

    typedef struct packed {
        logic             low_hit;
        logic             high_hit;
        logic             switch_on;
        logic [RPT_W-1:0] report_sample;
        logic [RPT_W-1:0] report_low;
        logic [RPT_W-1:0] report_high;
    } pkd_result_t;

    // avg + x - floor((avg - R) / 2^FRAC_SHIFT), wrapping at AVG_W bits
    function automatic logic [AVG_W-1:0] avg_update(
        input logic [SAMPLE_BITS-1:0] x,
        input logic [AVG_W-1:0]       avg
    );
        logic [AVG_W-1:0] dec;
        if (avg >= ROUND_OFS)
        begin
            dec = (avg - ROUND_OFS) >> FRAC_SHIFT;
        end
        else
        begin
            dec = '1;  // floor of a small negative is -1
        end
        return AVG_W'(x) + avg - dec;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/pkd_cfg_regs.sv]
// Configuration registers: noise padding and hold countdown reload.
// Depends on pkd_pkg.
`default_nettype none

module pkd_cfg_regs
    import pkd_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_wdata,
    output logic      [BAND_FLOOR_W-1:0] band_floor,
    output logic      [HOLD_W-1:0]       hold_count
);

    logic [BAND_FLOOR_W-1:0] band_floor_reg;
    logic [HOLD_W-1:0]       hold_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_floor_reg <= BAND_FLOOR_RST;
            hold_count_reg <= HOLD_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_IDX_BAND_FLOOR: band_floor_reg <= cfg_wdata[BAND_FLOOR_W-1:0];
                CFG_IDX_HOLD_COUNT: hold_count_reg <= cfg_wdata[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    assign band_floor = band_floor_reg;
    assign hold_count = hold_count_reg;

endmodule

`default_nettype wire

[hw/rtl/pkd_step.sv]
// Per-sample datapath: average updates, noise band, threshold tests, hold logic.
// Depends on pkd_pkg.
`default_nettype none

module pkd_step
    import pkd_pkg::*;
(
    input  wire logic [SAMPLE_BITS-1:0]  sample,
    input  wire pkd_state_t              state_cur,
    input  wire logic [BAND_FLOOR_W-1:0] band_floor,
    input  wire logic [HOLD_W-1:0]       hold_count,
    output pkd_state_t                   state_nxt,
    output pkd_result_t                  result
);

    logic [AVG_W-1:0] mid_n;
    logic [AVG_W-1:0] high_n;
    logic [AVG_W-1:0] low_n;
    logic [CTR_W-1:0] x_c;
    logic [CTR_W-1:0] centre;
    logic [AVG_W-1:0] noise;
    logic [AVG_W-1:0] lo_diff;
    logic [AVG_W:0]   hi_sum;
    logic             lo;
    logic             hi;

    always_comb
    begin
        x_c    = CTR_W'(sample);
        mid_n  = avg_update(sample, state_cur.mid_avg);
        centre = mid_n[AVG_W-1:FRAC_SHIFT];
        high_n = (x_c > centre) ? avg_update(sample, state_cur.high_avg)
                                : state_cur.high_avg;
        low_n  = (x_c < centre) ? avg_update(sample, state_cur.low_avg)
                                : state_cur.low_avg;
        noise  = high_n - low_n + AVG_W'(band_floor);

        // lower bound is signed: no low hit possible when mid is below the band
        lo_diff = mid_n - noise;
        hi_sum  = {1'b0, mid_n} + {1'b0, noise};
        lo      = (mid_n >= noise) && (x_c < lo_diff[AVG_W-1:FRAC_SHIFT]);
        hi      = !lo && ({1'b0, x_c} > hi_sum[AVG_W:FRAC_SHIFT]);

        state_nxt.mid_avg  = mid_n;
        state_nxt.high_avg = high_n;
        state_nxt.low_avg  = low_n;
        if (lo || hi)
        begin
            state_nxt.switch_level = 1'b1;
            state_nxt.hold_left    = hold_count;
        end
        else if (state_cur.hold_left != '0)
        begin
            state_nxt.switch_level = state_cur.switch_level;
            state_nxt.hold_left    = state_cur.hold_left - HOLD_W'(1);
        end
        else
        begin
            state_nxt.switch_level = 1'b0;
            state_nxt.hold_left    = state_cur.hold_left;
        end

        result.low_hit       = lo;
        result.high_hit      = hi;
        result.switch_on     = state_nxt.switch_level;
        result.report_sample = sample[RPT_W-1:0] - REPORT_OFS;
        result.report_low    = low_n[FRAC_SHIFT +: RPT_W] - REPORT_OFS;
        result.report_high   = high_n[FRAC_SHIFT +: RPT_W] - REPORT_OFS;
    end

endmodule

`default_nettype wire

[hw/rtl/piezo_knock_detector.sv]
// A request accepted into the input register moves into the result register once the
// output is free. Throughput: one request per cycle while out_ready does not stall.
// The input register takes one more request while a result waits on out_ready.
// Reset (async, active low) empties both stages, loads averages 510/520/500,
// clears the hold countdown and switch, and sets band_floor 16, hold_count 200.
`default_nettype none

module piezo_knock_detector
    import pkd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [SAMPLE_BITS-1:0] sample,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic                        low_hit,
    output logic                        high_hit,
    output logic                        switch_on,
    output logic      [RPT_W-1:0]       report_sample,
    output logic      [RPT_W-1:0]       report_low,
    output logic      [RPT_W-1:0]       report_high
);

    logic [BAND_FLOOR_W-1:0] band_floor;
    logic [HOLD_W-1:0]       hold_count;

    logic                   s1_valid_reg;
    logic [SAMPLE_BITS-1:0] s1_sample_reg;
    logic                   out_valid_reg;
    pkd_result_t            result_reg;
    pkd_result_t            result_next;
    pkd_state_t             state_reg;
    pkd_state_t             state_next;
    logic                   out_free;
    logic                   s1_move;

    pkd_cfg_regs u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .band_floor (band_floor),
        .hold_count (hold_count)
    );

    pkd_step u_step (
        .sample     (s1_sample_reg),
        .state_cur  (state_reg),
        .band_floor (band_floor),
        .hold_count (hold_count),
        .state_nxt  (state_next),
        .result     (result_next)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{mid_avg:      MID_AVG_RST,
                               high_avg:     HIGH_AVG_RST,
                               low_avg:      LOW_AVG_RST,
                               hold_left:    '0,
                               switch_level: 1'b0};
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (s1_move)
            begin
                state_reg <= state_next;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_sample_reg <= sample;
        end
        if (s1_move)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign low_hit       = result_reg.low_hit;
    assign high_hit      = result_reg.high_hit;
    assign switch_on     = result_reg.switch_on;
    assign report_sample = result_reg.report_sample;
    assign report_low    = result_reg.report_low;
    assign report_high   = result_reg.report_high;

endmodule

`default_nettype wire

[hw/rtl/pkd_checker.sv]
// Port-level checks for the knock detector, bound onto the top level.
// Depends on pkd_pkg and piezo_knock_detector_defines.svh.
`default_nettype none
`include "piezo_knock_detector_defines.svh"

module pkd_checker
    import pkd_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             in_ready,
    input wire logic             out_valid,
    input wire logic             out_ready,
    input wire logic             low_hit,
    input wire logic             high_hit,
    input wire logic             switch_on,
    input wire logic [RPT_W-1:0] report_sample,
    input wire logic [RPT_W-1:0] report_low,
    input wire logic [RPT_W-1:0] report_high
);

    logic                   out_stall;
    logic [3+3*RPT_W-1:0]   out_payload;

    assign out_stall   = out_valid && !out_ready;
    assign out_payload = {low_hit, high_hit, switch_on, report_sample, report_low, report_high};

    // a stalled result keeps its payload
    `PKD_ASSERT(a_out_hold, out_stall |=> out_valid && $stable(out_payload), "stalled result changed")

    // lower test wins, so both hits never show together
    `PKD_ASSERT(a_hit_excl, out_valid |-> !(low_hit && high_hit), "both hits set")

    `PKD_ASSERT(a_hit_switch, out_valid && (low_hit || high_hit) |-> switch_on, "hit without switch on")

    // with no result pending the input stage can always drain
    `PKD_ASSERT_ALWAYS(a_ready_free, !out_valid |-> in_ready, "input blocked with empty output")

endmodule

bind piezo_knock_detector pkd_checker u_pkd_checker (.*);

`default_nettype wire
